>>> rtl/ffud_pkg.sv
// Package for the form field extractor with URL decoding.
// Holds the item types, phase and escape codes, character constants and hex helpers.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package ffud_pkg;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       body_last;
    } body_item_t;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       is_report;
        logic       found;
        logic [7:0] value_length;
    } result_item_t;

    // All results that one body byte causes: up to three data bytes, then a report.
    typedef struct packed {
        logic [1:0]      n_data;
        logic [2:0][7:0] data;
        logic            has_report;
        logic            found;
        logic [7:0]      length;
    } bundle_t;

    typedef struct packed {
        logic head_valid;
        logic full;
    } queue_status_t;

    typedef enum logic [1:0] {
        PH_MATCH,
        PH_SKIP,
        PH_VALUE,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_PERCENT,
        ESC_DIGIT
    } escape_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    localparam logic [1:0] CFG_KEY_BYTES   = 2'd0;
    localparam logic [1:0] CFG_KEY_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_VALUE_LIMIT = 2'd2;

    localparam logic [3:0] KEY_LENGTH_RESET  = 4'd4;
    localparam logic [7:0] VALUE_LIMIT_RESET = 8'd32;

    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_AMP     = 8'h26;
    localparam logic [7:0] CHAR_SEMI    = 8'h3B;
    localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66)
            || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/form_field_extract_url_decode_unit.sv
// Top level of the form field extractor with URL decoding.
// Connects ffud_front, ffud_queue and ffud_back; depends on ffud_pkg.
// The block takes one body byte per cycle and decodes it in that same cycle in the
// front part; each byte yields zero to four result items (decoded bytes and the closing
// report), which pass through a four-entry queue and leave one per cycle, while ready is high,
// from the output register of the back part. Input stalls only when the queue is full, which
// happens when bytes produce more than one result on average or the consumer holds ready low.
// Each result is written into a queue slot and then into the output register before it is shown.
`timescale 1ns / 1ps
`default_nettype none

module form_field_extract_url_decode_unit
    import ffud_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_write,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [63:0]  cfg_data,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire body_item_t   in_item,
    output logic              out_valid,
    input  wire logic         out_ready,
    output result_item_t      out_item
);

    queue_status_t q_status;
    logic          push_valid;
    bundle_t       push_bundle;
    bundle_t       head;
    logic          pop;

    ffud_front #(
        .MAX_KEY_BYTES(MAX_KEY_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .q_status   (q_status),
        .push_valid (push_valid),
        .push_bundle(push_bundle)
    );

    ffud_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_bundle(push_bundle),
        .pop        (pop),
        .q_status   (q_status),
        .head       (head)
    );

    ffud_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head     (head),
        .pop      (pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item)
    );

endmodule

`default_nettype wire

>>> rtl/ffud_front.sv
// Front part: configuration registers, key matching and URL decoding of each body byte.
// Produces at most one result bundle per item; depends on ffud_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffud_front
    import ffud_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_write,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [63:0]   cfg_data,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire body_item_t    in_item,
    input  wire queue_status_t q_status,
    output logic               push_valid,
    output bundle_t            push_bundle
);

    localparam int KPW = $clog2(MAX_KEY_BYTES + 1);
    localparam int KIW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [3:0] MAX_LEN = 4'(MAX_KEY_BYTES);

    logic [MAX_KEY_BYTES-1:0][7:0] key_reg;
    logic [3:0]                    key_length_reg;
    logic [7:0]                    value_limit_reg;

    phase_t           phase_reg, phase_next;
    logic [KPW-1:0]   kpos_reg, kpos_next;
    escape_t          esc_reg, esc_next;
    logic [7:0]       held_reg, held_next;
    logic [7:0]       count_reg, count_next;

    logic             accept;
    logic [7:0]       c;
    logic             sep;
    logic [3:0]       klen;
    logic [7:0]       want;
    logic [2:0][7:0]  cand;
    logic [1:0]       ncand;
    logic [7:0]       count_base;
    logic [7:0]       room;
    logic [7:0]       n_emit;
    logic             rep;
    logic             rep_found;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign c        = in_item.body_byte;
    assign sep      = (c == CHAR_AMP) || (c == CHAR_SEMI);
    assign klen     = (key_length_reg > MAX_LEN) ? MAX_LEN : key_length_reg;
    assign want     = key_reg[kpos_reg[KIW-1:0]];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            key_reg         <= '0;
            key_length_reg  <= KEY_LENGTH_RESET;
            value_limit_reg <= VALUE_LIMIT_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_KEY_BYTES:   key_reg         <= cfg_data[8*MAX_KEY_BYTES-1:0];
                CFG_KEY_LENGTH:  key_length_reg  <= cfg_data[3:0];
                CFG_VALUE_LIMIT: value_limit_reg <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        kpos_next  = kpos_reg;
        esc_next   = esc_reg;
        held_next  = held_reg;
        count_base = count_reg;
        cand       = '0;
        ncand      = 2'd0;
        rep        = 1'b0;
        rep_found  = 1'b0;

        unique case (phase_reg)
            PH_MATCH:
            begin
                if (sep) begin
                    kpos_next = '0;
                end else if (4'(kpos_reg) < klen) begin
                    if (c == want) begin
                        kpos_next = kpos_reg + KPW'(1);
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end else if (c == CHAR_EQUAL) begin
                    phase_next = PH_VALUE;
                    esc_next   = ESC_NONE;
                    count_base = 8'd0;
                end else begin
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                if (sep) begin
                    phase_next = PH_MATCH;
                    kpos_next  = '0;
                end
            end
            PH_VALUE:
            begin
                if (sep) begin
                    if (esc_next == ESC_PERCENT) begin
                        cand[ncand] = CHAR_PERCENT;
                        ncand       = ncand + 2'd1;
                    end else if (esc_next == ESC_DIGIT) begin
                        cand[ncand] = CHAR_PERCENT;
                        ncand       = ncand + 2'd1;
                        cand[ncand] = held_next;
                        ncand       = ncand + 2'd1;
                    end
                    esc_next   = ESC_NONE;
                    rep        = 1'b1;
                    rep_found  = 1'b1;
                    phase_next = PH_DONE;
                end else begin
                    logic plain;
                    plain = 1'b0;
                    unique case (esc_reg)
                        ESC_PERCENT:
                        begin
                            if (is_hex(c)) begin
                                held_next = c;
                                esc_next  = ESC_DIGIT;
                            end else begin
                                cand[ncand] = CHAR_PERCENT;
                                ncand       = ncand + 2'd1;
                                esc_next    = ESC_NONE;
                                plain       = 1'b1;
                            end
                        end
                        ESC_DIGIT:
                        begin
                            if (is_hex(c)) begin
                                cand[ncand] = {hex_value(held_reg), hex_value(c)};
                                ncand       = ncand + 2'd1;
                                esc_next    = ESC_NONE;
                            end else begin
                                cand[ncand] = CHAR_PERCENT;
                                ncand       = ncand + 2'd1;
                                cand[ncand] = held_reg;
                                ncand       = ncand + 2'd1;
                                esc_next    = ESC_NONE;
                                plain       = 1'b1;
                            end
                        end
                        default:
                        begin
                            plain = 1'b1;
                        end
                    endcase
                    if (plain) begin
                        if (c == CHAR_PLUS) begin
                            cand[ncand] = CHAR_SPACE;
                            ncand       = ncand + 2'd1;
                        end else if (c == CHAR_PERCENT) begin
                            esc_next = ESC_PERCENT;
                        end else begin
                            cand[ncand] = c;
                            ncand       = ncand + 2'd1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (in_item.body_last) begin
            if (phase_next == PH_VALUE) begin
                if (esc_next == ESC_PERCENT) begin
                    cand[ncand] = CHAR_PERCENT;
                    ncand       = ncand + 2'd1;
                end else if (esc_next == ESC_DIGIT) begin
                    cand[ncand] = CHAR_PERCENT;
                    ncand       = ncand + 2'd1;
                    cand[ncand] = held_next;
                    ncand       = ncand + 2'd1;
                end
                rep       = 1'b1;
                rep_found = 1'b1;
            end else if (phase_next != PH_DONE) begin
                rep = 1'b1;
            end
        end

        room       = (count_base < value_limit_reg) ? (value_limit_reg - count_base) : 8'd0;
        n_emit     = (8'(ncand) > room) ? room : 8'(ncand);
        count_next = count_base + n_emit;

        if (in_item.body_last) begin
            phase_next = PH_MATCH;
            kpos_next  = '0;
            esc_next   = ESC_NONE;
            held_next  = 8'd0;
        end
    end

    always_comb
    begin
        push_bundle.n_data     = n_emit[1:0];
        push_bundle.data       = cand;
        push_bundle.has_report = rep;
        push_bundle.found      = rep_found;
        push_bundle.length     = rep_found ? count_next : 8'd0;
        push_valid             = accept && ((n_emit != 8'd0) || rep);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg <= PH_MATCH;
            kpos_reg  <= '0;
            esc_reg   <= ESC_NONE;
            held_reg  <= 8'd0;
            count_reg <= 8'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            kpos_reg  <= kpos_next;
            esc_reg   <= esc_next;
            held_reg  <= held_next;
            count_reg <= in_item.body_last ? 8'd0 : count_next;
        end
    end

    a_found_has_report: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && push_bundle.found |-> push_bundle.has_report)
        else $error("found flag set on a bundle without a report");

    a_not_found_zero_length: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && push_bundle.has_report && !push_bundle.found
            |-> push_bundle.length == 8'd0 && push_bundle.n_data == 2'd0)
        else $error("missing-key report carries data or a length");

endmodule

`default_nettype wire

>>> rtl/ffud_queue.sv
// Short bundle queue between the front and back parts.
// Register slots with read and write pointers; depends on ffud_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffud_queue
    import ffud_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push_valid,
    input  wire bundle_t push_bundle,
    input  wire logic    pop,
    output queue_status_t q_status,
    output bundle_t      head
);

    bundle_t                slots_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;

    assign q_status.head_valid = (count_reg != '0);
    assign q_status.full       = (count_reg == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign head                = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push_valid && !pop) begin
            count_next = count_reg + (QUEUE_PTR_W + 1)'(1);
        end else if (pop && !push_valid) begin
            count_next = count_reg - (QUEUE_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk) begin
        if (push_valid) begin
            slots_reg[wr_ptr_reg] <= push_bundle;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_valid) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> !q_status.full)
        else $error("bundle pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_status.head_valid)
        else $error("bundle popped from an empty queue");

endmodule

`default_nettype wire

>>> rtl/ffud_back.sv
// Back part: walks the head bundle one result at a time into a registered output.
// Pops the queue when the bundle's last result is loaded; depends on ffud_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffud_back
    import ffud_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire queue_status_t q_status,
    input  wire bundle_t       head,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output result_item_t       out_item
);

    logic [1:0]   sub_reg;
    logic         out_valid_reg;
    result_item_t out_item_reg;
    logic [2:0]   total;
    logic         last_of_bundle;
    logic         load;
    result_item_t next_item;

    assign total          = 3'(head.n_data) + 3'(head.has_report);
    assign last_of_bundle = (3'(sub_reg) + 3'd1 == total);
    assign load           = q_status.head_valid && (!out_valid_reg || out_ready);
    assign pop            = load && last_of_bundle;
    assign out_valid      = out_valid_reg;
    assign out_item       = out_item_reg;

    always_comb
    begin
        if (sub_reg < head.n_data) begin
            next_item.value_byte   = head.data[sub_reg];
            next_item.is_report    = 1'b0;
            next_item.found        = 1'b0;
            next_item.value_length = 8'd0;
        end else begin
            next_item.value_byte   = 8'd0;
            next_item.is_report    = 1'b1;
            next_item.found        = head.found;
            next_item.value_length = head.length;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            out_item_reg <= next_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sub_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                out_valid_reg <= 1'b1;
                sub_reg       <= last_of_bundle ? 2'd0 : sub_reg + 2'd1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_sub_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.head_valid |-> 3'(sub_reg) < total)
        else $error("result index runs past the head bundle");

    a_found_only_in_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.found |-> out_item_reg.is_report)
        else $error("found flag on a data item");

endmodule

`default_nettype wire
